>>> sv/secondary_electron_yield_macros.svh
`ifndef SECONDARY_ELECTRON_YIELD_MACROS_SVH
`define SECONDARY_ELECTRON_YIELD_MACROS_SVH

// checks sampled on clk, off while arst_n is low
`define SEY_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define SEY_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> sv/sey_pkg.sv
package sey_pkg;

	localparam int MAX_VEL_DIMS_DEF = 3;
	localparam int VEL_WIDTH_DEF    = 24;
	localparam int LOG_STEPS        = 16;
	localparam int EXP_STEPS        = 16;
	localparam int DIV_STEPS        = 16;

	typedef enum logic [1:0] {
		REG_VEL_DIMS     = 2'd0,
		REG_ENERGY_SCALE = 2'd1,
		REG_PEAK_YIELD   = 2'd2,
		REG_SHAPE_S      = 2'd3
	} sey_reg_t;

	localparam logic [13:0] ONE_Q12    = 14'd4096;
	localparam logic [13:0] SHAPE_MIN  = 14'd4097;
	localparam logic [15:0] YIELD_MAX  = 16'hFFFF;
	localparam logic [8:0]  N_BIG      = 9'd34;
	localparam logic [8:0]  N_Q20      = 9'd10;

	typedef struct packed {
		logic valid;
		logic force_zero;
		logic clip_x;
	} sey_side_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] yield_value;
		logic        clipped;
	} sey_res_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] res;
		logic [63:0] bitv;
		rem  = v;
		res  = '0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// 2^(2^-k) in Q.30
	function automatic logic [31:0] exp_rom_val(int k);
		logic [63:0] c;
		c = 64'd1 << 31;
		for (int j = 1; j <= k; j++) c = isqrt64(c << 30);
		return c[31:0];
	endfunction

endpackage

>>> sv/sey_div.sv
module sey_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  sey_pkg::sey_side_t  side_in,
	input  logic [61:0]         num,
	input  logic [63:0]         dnm,
	output sey_pkg::sey_res_t   res
);
	import sey_pkg::*;

	localparam int N = DIV_STEPS;

	logic [61:0] rem_d  [0:N];
	logic [63:0] dnm_d  [0:N];
	logic [15:0] q_d    [0:N];
	logic        sat_d  [0:N];
	sey_side_t   side_d [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_d[0] <= '0;
		end else if (en) begin
			side_d[0] <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_d[0] <= num;
			dnm_d[0] <= dnm;
			sat_d[0] <= {18'd0, num} >= {dnm, 16'd0};
		end
	end

	assign q_d[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int SH = N - 1 - k;
		logic [79:0] shifted;
		logic        ge;
		assign shifted = {16'd0, dnm_d[k]} << SH;
		assign ge      = {18'd0, rem_d[k]} >= shifted;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_d[k+1] <= '0;
			end else if (en) begin
				side_d[k+1] <= side_d[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_d[k+1] <= ge ? rem_d[k] - shifted[61:0] : rem_d[k];
				q_d[k+1]   <= {q_d[k][14:0], ge};
				dnm_d[k+1] <= dnm_d[k];
				sat_d[k+1] <= sat_d[k];
			end
		end
	end

	always_comb begin
		res.valid = side_d[N].valid;
		if (side_d[N].force_zero) begin
			res.yield_value = '0;
			res.clipped     = side_d[N].clip_x;
		end else if (sat_d[N]) begin
			res.yield_value = YIELD_MAX;
			res.clipped     = 1'b1;
		end else begin
			res.yield_value = q_d[N];
			res.clipped     = side_d[N].clip_x;
		end
	end

endmodule

>>> sv/secondary_electron_yield.sv
// Furman-Pivi true-secondary yield at normal incidence, one particle per request.
// Slave stream: tdata carries vel_x, vel_y, vel_z (VEL_WIDTH bits each, signed).
// Master stream: tdata carries yield_value (Q4.12), tuser carries clipped.
// Config channel: cfg_valid/cfg_ready with cfg_index (0 vel_dims, 1 energy_scale,
// 2 peak_yield, 3 shape_s) and cfg_data; always ready. Write only while idle.
// Throughput: one request per cycle while s_axis_tready is high.
// Pipeline: 5 energy stages, 16 log2 squaring stages, 2 exponent stages,
// 16 exp2 ROM-multiply stages, 1 denominator stage, 17 restoring divide
// stages and the output register.
// Reset: pipeline and output empty, registers at vel_dims 3, energy_scale 65536,
// peak_yield 8192, shape_s 6144.
// Stall: a result waits in the output register; one more goes to a skid slot,
// after which s_axis_tready drops and the whole pipeline holds.
`include "secondary_electron_yield_macros.svh"

module secondary_electron_yield #(
	parameter int MAX_VEL_DIMS = sey_pkg::MAX_VEL_DIMS_DEF,
	parameter int VEL_WIDTH    = sey_pkg::VEL_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [((3*VEL_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // vel_x, vel_y, vel_z
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [15:0]                           m_axis_tdata,  // yield_value
	output logic [0:0]                            m_axis_tuser,  // clipped
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [31:0]                           cfg_data
);
	import sey_pkg::*;

	localparam int W = VEL_WIDTH;

	logic [1:0]  vel_dims_q;
	logic [31:0] energy_scale_q;
	logic [15:0] peak_yield_q;
	logic [13:0] shape_s_q;
	logic [29:0] ps_q;
	logic [13:0] s_eff;
	logic [13:0] sm1;
	logic [1:0]  dims_eff;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_dims_q     <= 2'd3;
			energy_scale_q <= 32'd65536;
			peak_yield_q   <= 16'd8192;
			shape_s_q      <= 14'd6144;
		end else if (cfg_valid) begin
			unique case (sey_reg_t'(cfg_index))
				REG_VEL_DIMS:     vel_dims_q     <= cfg_data[1:0];
				REG_ENERGY_SCALE: energy_scale_q <= cfg_data;
				REG_PEAK_YIELD:   peak_yield_q   <= cfg_data[15:0];
				REG_SHAPE_S:      shape_s_q      <= cfg_data[13:0];
				default:          vel_dims_q     <= vel_dims_q;
			endcase
		end
	end

	assign s_eff    = (shape_s_q < SHAPE_MIN) ? SHAPE_MIN : shape_s_q;
	assign sm1      = s_eff - ONE_Q12;
	assign dims_eff = (vel_dims_q > 2'(MAX_VEL_DIMS)) ? 2'(MAX_VEL_DIMS) : vel_dims_q;

	always_ff @(posedge clk) begin
		ps_q <= peak_yield_q * s_eff;
	end

	logic en;
	logic sk_v_q;
	assign en            = !sk_v_q;
	assign s_axis_tready = en;

	// s1: magnitudes squared
	logic [2*W-1:0] sq_s1 [MAX_VEL_DIMS];
	logic           v_s1;

	for (genvar i = 0; i < MAX_VEL_DIMS; i++) begin : g_lane
		logic [W-1:0]   vel;
		logic [W-1:0]   mag;
		assign vel = s_axis_tdata[i*W +: W];
		assign mag = vel[W-1] ? (~vel + W'(1)) : vel;
		always_ff @(posedge clk) begin
			if (en) sq_s1[i] <= (2'(i) < dims_eff) ? mag * mag : '0;
		end
	end

	// s2: sum
	logic [63:0] sum_c;
	logic [63:0] sum_s2;
	logic        v_s2;
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < MAX_VEL_DIMS; i++) sum_c = sum_c + 64'(sq_s1[i]);
	end

	// s3: scale products
	logic [63:0] phi_s3, plo_s3;
	logic        v_s3;

	// s4: x in Q16.16
	logic [64:0] xw;
	logic [31:0] xq_s4;
	sey_side_t   side_s4;
	assign xw = {1'b0, phi_s3} + {33'd0, plo_s3[63:32]};

	// s5: normalize, numerator
	logic [4:0]  b_c;
	always_comb begin
		b_c = '0;
		for (int j = 0; j < 32; j++) if (xq_s4[j]) b_c = 5'(j);
	end

	logic [31:0] m_lg    [0:LOG_STEPS];
	logic [15:0] frac_lg [0:LOG_STEPS];
	logic [4:0]  b_lg    [0:LOG_STEPS];
	logic [61:0] num_lg  [0:LOG_STEPS];
	sey_side_t   side_lg [0:LOG_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			side_s4    <= '0;
			side_lg[0] <= '0;
		end else if (en) begin
			v_s1       <= s_axis_tvalid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			side_s4    <= '{valid: v_s3, force_zero: 1'b0, clip_x: xw[64:32] != '0};
			side_lg[0] <= '{valid: side_s4.valid, force_zero: xq_s4 == '0,
				clip_x: side_s4.clip_x};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2     <= sum_c;
			phi_s3     <= energy_scale_q * sum_s2[63:32];
			plo_s3     <= energy_scale_q * sum_s2[31:0];
			xq_s4      <= (xw[64:32] != '0) ? 32'hFFFF_FFFF : xw[31:0];
			m_lg[0]    <= xq_s4 << (5'd31 - b_c);
			frac_lg[0] <= '0;
			b_lg[0]    <= b_c;
			num_lg[0]  <= ps_q * xq_s4;
		end
	end

	// s6..s21: log2 fraction, one bit per squaring
	for (genvar k = 0; k < LOG_STEPS; k++) begin : g_log
		logic [63:0] sq;
		logic [32:0] t;
		assign sq = m_lg[k] * m_lg[k];
		assign t  = sq[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_lg[k+1] <= '0;
			else if (en) side_lg[k+1] <= side_lg[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_lg[k+1]    <= t[32] ? t[32:1] : t[31:0];
				frac_lg[k+1] <= {frac_lg[k][14:0], t[32]};
				b_lg[k+1]    <= b_lg[k];
				num_lg[k+1]  <= num_lg[k];
			end
		end
	end

	// s22: s * log2 x
	logic signed [21:0] lg;
	logic signed [36:0] spp_s22;
	logic [61:0]        num_s22;
	sey_side_t          side_s22;
	assign lg = $signed({6'({1'b0, b_lg[LOG_STEPS]}) - 6'd16, frac_lg[LOG_STEPS]});

	// s23: integer and fraction of the exponent
	logic [24:0] sp;
	assign sp = spp_s22[36:12];

	logic [31:0] r_ex    [0:EXP_STEPS];
	logic [15:0] f_ex    [0:EXP_STEPS];
	logic [8:0]  n_ex    [0:EXP_STEPS];
	logic [61:0] num_ex  [0:EXP_STEPS];
	sey_side_t   side_ex [0:EXP_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s22   <= '0;
			side_ex[0] <= '0;
		end else if (en) begin
			side_s22   <= side_lg[LOG_STEPS];
			side_ex[0] <= '{valid: side_s22.valid,
				force_zero: side_s22.force_zero || ($signed(sp[24:16]) >= $signed(N_BIG)),
				clip_x: side_s22.clip_x};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spp_s22   <= $signed({1'b0, s_eff}) * lg;
			num_s22   <= num_lg[LOG_STEPS];
			r_ex[0]   <= 32'd1 << 30;
			f_ex[0]   <= sp[15:0];
			n_ex[0]   <= sp[24:16];
			num_ex[0] <= num_s22;
		end
	end

	// s24..s39: exp2 of the fraction from the ROM
	for (genvar k = 1; k <= EXP_STEPS; k++) begin : g_exp
		localparam logic [31:0] C = exp_rom_val(k);
		logic [63:0] pr;
		assign pr = r_ex[k-1] * C;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) side_ex[k] <= '0;
			else if (en) side_ex[k] <= side_ex[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_ex[k]   <= f_ex[k-1][EXP_STEPS-k] ? pr[61:30] : r_ex[k-1];
				f_ex[k]   <= f_ex[k-1];
				n_ex[k]   <= n_ex[k-1];
				num_ex[k] <= num_ex[k-1];
			end
		end
	end

	// s40: denominator in Q.28
	logic [8:0]  n_f;
	logic [31:0] r_f;
	logic [8:0]  lsh;
	logic [9:0]  rsh;
	logic [55:0] ppow;
	logic [63:0] dnm_s40;
	logic [61:0] num_s40;
	sey_side_t   side_s40;

	assign n_f = n_ex[EXP_STEPS];
	assign r_f = r_ex[EXP_STEPS];
	assign lsh = n_f - N_Q20;
	assign rsh = 10'(N_Q20) - {n_f[8], n_f};

	always_comb begin
		if ($signed(n_f) >= $signed(N_Q20)) ppow = {24'd0, r_f} << lsh[4:0];
		else if (rsh >= 10'd32) ppow = '0;
		else ppow = {24'd0, r_f >> rsh[4:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_s40 <= '0;
		else if (en) side_s40 <= side_ex[EXP_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dnm_s40 <= {(({42'd0, sm1} << 8) + ppow), 8'd0};
			num_s40 <= num_ex[EXP_STEPS];
		end
	end

	sey_res_t res;

	sey_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.side_in (side_s40),
		.num     (num_s40),
		.dnm     (dnm_s40),
		.res     (res)
	);

	// output register plus skid slot
	logic        out_v_q;
	logic [15:0] out_y_q, sk_y_q;
	logic        out_c_q, sk_c_q;
	logic        push, take;

	assign push = en && res.valid;
	assign take = out_v_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
			out_y_q <= '0;
			out_c_q <= 1'b0;
			sk_y_q  <= '0;
			sk_c_q  <= 1'b0;
		end else if (take) begin
			if (sk_v_q) begin
				out_y_q <= sk_y_q;
				out_c_q <= sk_c_q;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= push;
				out_y_q <= res.yield_value;
				out_c_q <= res.clipped;
			end
		end else if (push) begin
			if (out_v_q) begin
				sk_y_q <= res.yield_value;
				sk_c_q <= res.clipped;
				sk_v_q <= 1'b1;
			end else begin
				out_y_q <= res.yield_value;
				out_c_q <= res.clipped;
				out_v_q <= 1'b1;
			end
		end
	end

	assign m_axis_tvalid   = out_v_q;
	assign m_axis_tdata    = out_y_q;
	assign m_axis_tuser[0] = out_c_q;

	`SEY_ASSERT_IMPL(a_skid_has_head, sk_v_q, out_v_q)
	`SEY_ASSERT_NEXT(a_skid_fill, push && out_v_q && !take, sk_v_q)
	`SEY_ASSERT_NEXT(a_skid_drain, take && sk_v_q, out_v_q && !sk_v_q)

endmodule
